// ----- design/rlmu_pkg.sv -----
// rlmu_pkg: shared types and constants for the ranked list move-up block
// depends on nothing
`timescale 1ns / 1ps
package rlmu_pkg;

    localparam int SLOTS_DEF = 64;

    localparam int ID_W     = 8;
    localparam int SCORE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } t_slot;

endpackage

// ----- design/ranked_list_move_up_top.sv -----
// ranked_list_move_up_top: ranked list of id/score slots with append and move-up on update
// depends on rlmu_pkg
`timescale 1ns / 1ps
//
//  channel   | handshake                  | word
//  ----------+----------------------------+--------------------------------------
//  request   | start in, busy out         | i_req_type, i_entry_id, i_new_score
//  result    | o_valid out, one cycle     | o_status, o_rank_position
//
//  append: never busy, result strobe in the cycle after the accept. update: busy while it
//  searches the slots from slot 0 for the id, then moves the entry up past lower scores, each
//  slot a read state then a compare state, set by the single read port of the slot memory.
//  not found: busy while all occupied slots are searched. the result strobe comes in the
//  first cycle with busy low, so the next request may start in that cycle. reset empties
//  the list at once (count cleared). the receiver cannot stall.
module ranked_list_move_up_top #(
    parameter int SLOTS = rlmu_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [rlmu_pkg::ID_W-1:0]     i_entry_id,
    input  logic [rlmu_pkg::SCORE_W-1:0]  i_new_score,
    output logic                          o_valid,
    output logic [rlmu_pkg::STATUS_W-1:0] o_status,
    output logic [rlmu_pkg::POS_W-1:0]    o_rank_position
);
    import rlmu_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRD  = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_URD  = 3'd3;
    localparam logic [2:0] S_UCMP = 3'd4;

    t_slot r_mem [SLOTS];
    t_slot r_rdata;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_k, n_k;
    logic [ID_W-1:0]     r_id, n_id;
    logic [SCORE_W-1:0]  r_score, n_score;
    logic                r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [POS_W-1:0]    r_pos, n_pos;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [IW-1:0] w_raddr;
    t_slot         w_wdata;
    logic [CW-1:0] w_km1;

    assign w_km1 = r_k - 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_k      = r_k;
        n_id     = r_id;
        n_score  = r_score;
        n_valid  = 1'b0;
        n_status = r_status;
        n_pos    = r_pos;
        w_we     = 1'b0;
        w_waddr  = r_k[IW-1:0];
        w_raddr  = r_k[IW-1:0];
        w_wdata  = '{id: r_id, score: r_score};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_id    = i_entry_id;
                    n_score = i_new_score;
                    if (i_req_type == REQ_APPEND) begin
                        n_valid = 1'b1;
                        if (r_count >= SLOTS_C) begin
                            n_status = ST_FULL;
                            n_pos    = '0;
                        end else begin
                            w_we     = 1'b1;
                            w_waddr  = r_count[IW-1:0];
                            w_wdata  = '{id: i_entry_id, score: i_new_score};
                            n_count  = r_count + 1'b1;
                            n_status = ST_OK;
                            n_pos    = POS_W'(r_count);
                        end
                    end else begin
                        n_k     = '0;
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                if (r_k == r_count) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_pos    = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (r_rdata.id == r_id) begin
                    n_state = S_URD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_URD: begin
                if (r_k == '0) begin
                    w_we     = 1'b1;
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_pos    = POS_W'(r_k);
                    n_state  = S_IDLE;
                end else begin
                    w_raddr = w_km1[IW-1:0];
                    n_state = S_UCMP;
                end
            end
            S_UCMP: begin
                w_we = 1'b1;
                if (r_rdata.score < r_score) begin
                    w_wdata = r_rdata;
                    n_k     = w_km1;
                    n_state = S_URD;
                end else begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_pos    = POS_W'(r_k);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_id     <= n_id;
        r_score  <= n_score;
        r_status <= n_status;
        r_pos    <= n_pos;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_rank_position = r_pos;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_C)
        else $error("slot count beyond capacity");

    a_err_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_rank_position == '0))
        else $error("nonzero position with error status");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("update finished without a result");

    a_append_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_APPEND) && (r_count < SLOTS_C))
        |=> (o_valid && (o_status == ST_OK) && (r_count == $past(r_count) + 1'b1)))
        else $error("append did not grow the list");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCMP) |-> (r_k < r_count))
        else $error("search past the occupied slots");
`endif

endmodule

// ----- verif/testbench.sv -----
// testbench: self-checking bench for ranked_list_move_up_top, a start/busy request port and a
// one-cycle result strobe, checked against an in-bench model of the ranked list
// depends on rlmu_pkg and ranked_list_move_up_top
`timescale 1ns / 1ps
module testbench;
    import rlmu_pkg::*;

    localparam int NUM_SLOTS = SLOTS_DEF;
    localparam int RANDOM_WORDS = 600;
    localparam int SETTLE_CYCLES = 4 * NUM_SLOTS + 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    pos;
    } t_rank_result;

    typedef struct packed {
        logic                req;
        logic [ID_W-1:0]     id;
        logic [SCORE_W-1:0]  score;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    pos;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_req_type = REQ_APPEND;
    logic [ID_W-1:0]     i_entry_id = '0;
    logic [SCORE_W-1:0]  i_new_score = '0;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [POS_W-1:0]    o_rank_position;

    logic [ID_W-1:0]    ranked_ids [NUM_SLOTS];
    logic [SCORE_W-1:0] ranked_scores [NUM_SLOTS];
    int                 ranked_count = 0;

    t_rank_result pending_results [$];
    t_rank_result oldest_result;
    int mismatch_count = 0;
    int words_sent = 0;
    int results_seen = 0;
    int appends_done = 0;
    int full_rejects = 0;
    int id_misses = 0;
    int moves_up = 0;

    // rows from an empty list: misses, extremes, ties, lowered scores, duplicate ids
    t_stim_row directed_rows [16] = '{
        '{REQ_UPDATE, 8'h05, 16'h000a, 1'b1, ST_NOT_FOUND, 6'd0},
        '{REQ_APPEND, 8'h00, 16'h0000, 1'b1, ST_OK, 6'd0},
        '{REQ_APPEND, 8'hff, 16'hffff, 1'b1, ST_OK, 6'd1},
        '{REQ_APPEND, 8'h80, 16'h8000, 1'b1, ST_OK, 6'd2},
        '{REQ_UPDATE, 8'h80, 16'hffff, 1'b0, ST_OK, 6'd0},
        '{REQ_UPDATE, 8'hff, 16'h0001, 1'b0, ST_OK, 6'd0},
        '{REQ_UPDATE, 8'h80, 16'h0002, 1'b0, ST_OK, 6'd0},
        '{REQ_UPDATE, 8'h7f, 16'h1234, 1'b1, ST_NOT_FOUND, 6'd0},
        '{REQ_APPEND, 8'h00, 16'haaaa, 1'b1, ST_OK, 6'd3},
        '{REQ_UPDATE, 8'h00, 16'h5555, 1'b0, ST_OK, 6'd0},
        '{REQ_UPDATE, 8'h00, 16'hffff, 1'b0, ST_OK, 6'd0},
        '{REQ_APPEND, 8'h55, 16'h5555, 1'b1, ST_OK, 6'd4},
        '{REQ_APPEND, 8'haa, 16'haaaa, 1'b1, ST_OK, 6'd5},
        '{REQ_UPDATE, 8'haa, 16'hffff, 1'b0, ST_OK, 6'd0},
        '{REQ_UPDATE, 8'h55, 16'h0000, 1'b0, ST_OK, 6'd0},
        '{REQ_UPDATE, 8'haa, 16'h0000, 1'b0, ST_OK, 6'd0}
    };

    ranked_list_move_up_top #(
        .SLOTS(NUM_SLOTS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req_type(i_req_type),
        .i_entry_id(i_entry_id),
        .i_new_score(i_new_score),
        .o_valid(o_valid),
        .o_status(o_status),
        .o_rank_position(o_rank_position)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_rank_result rank_update(input logic req, input logic [ID_W-1:0] id,
                                                 input logic [SCORE_W-1:0] score);
        t_rank_result r;
        int k;
        int found_at;
        bit hit;
        r.status = ST_OK;
        r.pos = '0;
        hit = 1'b0;
        k = 0;
        if (req == REQ_APPEND) begin
            if (ranked_count >= NUM_SLOTS) begin
                r.status = ST_FULL;
                full_rejects++;
            end else begin
                ranked_ids[ranked_count] = id;
                ranked_scores[ranked_count] = score;
                r.pos = POS_W'(ranked_count);
                ranked_count++;
                appends_done++;
            end
        end else begin
            while (k < ranked_count && !hit) begin
                if (ranked_ids[k] == id) begin
                    hit = 1'b1;
                end else begin
                    k++;
                end
            end
            if (!hit) begin
                r.status = ST_NOT_FOUND;
                id_misses++;
            end else begin
                found_at = k;
                while (k > 0 && ranked_scores[k-1] < score) begin
                    ranked_ids[k] = ranked_ids[k-1];
                    ranked_scores[k] = ranked_scores[k-1];
                    k--;
                end
                ranked_ids[k] = id;
                ranked_scores[k] = score;
                r.pos = POS_W'(k);
                if (k < found_at) begin
                    moves_up++;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [SCORE_W-1:0] pick_score();
        logic [SCORE_W-1:0] s;
        case ($urandom_range(3))
            0: s = SCORE_W'($urandom_range(65535));
            1: s = $urandom_range(1) ? '1 : '0;
            2: s = (ranked_count > 0) ? ranked_scores[$urandom_range(ranked_count - 1)]
                                      : SCORE_W'($urandom_range(65535));
            default: s = SCORE_W'($urandom_range(15));
        endcase
        return s;
    endfunction

    // mostly updates of ids on the list, appends until full, a few misses and full rejects
    task automatic next_random_word(output logic req, output logic [ID_W-1:0] id,
                                    output logic [SCORE_W-1:0] score);
        int roll;
        int append_pct;
        roll = $urandom_range(99);
        append_pct = (ranked_count < NUM_SLOTS) ? 35 : 6;
        score = pick_score();
        if (roll < append_pct || ranked_count == 0) begin
            req = REQ_APPEND;
            if (ranked_count > 0 && $urandom_range(4) == 0) begin
                id = ranked_ids[$urandom_range(ranked_count - 1)];
            end else begin
                id = ID_W'($urandom_range(255));
            end
        end else if (roll < 92) begin
            req = REQ_UPDATE;
            id = ranked_ids[$urandom_range(ranked_count - 1)];
        end else begin
            req = REQ_UPDATE;
            id = ID_W'($urandom_range(255));
        end
    endtask

    task automatic send_word(input logic req, input logic [ID_W-1:0] id,
                             input logic [SCORE_W-1:0] score, input int idle_pct,
                             input logic typed, input t_rank_result typed_result);
        t_rank_result want;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req;
        i_entry_id <= id;
        i_new_score <= score;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        want = rank_update(req, id, score);
        pending_results.push_back(typed ? typed_result : want);
        words_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: status %0d rank_position %0d",
                       o_status, o_rank_position);
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_status !== oldest_result.status) begin
                    $error("status: expected %0d, actual %0d", oldest_result.status, o_status);
                    mismatch_count++;
                end
                if (o_rank_position !== oldest_result.pos) begin
                    $error("rank_position: expected %0d, actual %0d",
                           oldest_result.pos, o_rank_position);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #12_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int idle_by_phase [3];
        logic               req;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        idle_by_phase = '{0, 84, 25};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].req, directed_rows[i].id, directed_rows[i].score, 0,
                      directed_rows[i].typed, {directed_rows[i].status, directed_rows[i].pos});
        end

        // empty pipe between phases so the sender also waits on a fully idle block
        for (int phase = 0; phase < 3; phase++) begin
            drain_results();
            for (int n = 0; n < RANDOM_WORDS; n++) begin
                next_random_word(req, id, score);
                send_word(req, id, score, idle_by_phase[phase], 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end
        $display("covered %0d words, %0d results: %0d appends, %0d rejected on a full list,",
                 words_sent, results_seen, appends_done, full_rejects);
        $display("%0d updates of missing ids, %0d updates that moved an entry up",
                 id_misses, moves_up);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
design/rlmu_pkg.sv
design/ranked_list_move_up_top.sv
verif/testbench.sv
